// ----- hw/rtl/dbm_pkg.sv -----
// Package for the doorbell match table: table size, field codes and the
// request, response, table entry and compare result types.
// Depends on nothing; dbm_cmp, the core and dbm_chk use it.
package dbm_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] KIND_ASSIGN   = 2'd0;
  localparam logic [1:0] KIND_DEASSIGN = 2'd1;
  localparam logic [1:0] KIND_MMIO     = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_CONFLICT = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_SOFTWARE = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] notifier_id;
    logic [63:0] addr;
    logic [7:0]  space;
    logic [3:0]  length;
    logic [63:0] data;
    logic        data_match;
    logic        is_write;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        notify;
    logic [15:0] hit_notifier;
    logic [63:0] ack_data;
  } out_t;

  typedef struct packed {
    logic [63:0] addr;
    logic [7:0]  space;
    logic [3:0]  len;
    logic [63:0] data;
    logic        wild;
    logic [15:0] notifier;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic conflict;
    logic hit;
    logic nid_eq;
  } cmp_t;

endpackage

// ----- hw/rtl/dbm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module dbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/dbm_cmp.sv -----
// Shared compare unit: tests one table entry against the current word for
// an assign conflict, an mmio write hit and a notifier match. Uses dbm_pkg.
module dbm_cmp (
  input  dbm_pkg::entry_t ent,
  input  dbm_pkg::in_t    cur,
  output dbm_pkg::cmp_t   res
);

  logic key_eq;
  logic data_eq;
  logic len_eq;

  always_comb begin
    key_eq  = (ent.addr == cur.addr) && (ent.space == cur.space);
    data_eq = (ent.data == cur.data);
    len_eq  = (ent.len == cur.length);
    res.nid_eq   = (ent.notifier == cur.notifier_id);
    res.conflict = res.nid_eq && key_eq &&
                   ((ent.len == 4'd0) || (cur.length == 4'd0) ||
                    (len_eq && (ent.wild || !cur.data_match || data_eq)));
    res.hit      = key_eq &&
                   ((ent.len == 4'd0) || (len_eq && (ent.wild || data_eq)));
  end

endmodule

// ----- hw/rtl/mmio_write_doorbell_match_table_core.sv -----
// Top level of the doorbell match table: sequencer, table RAM and compare unit.
// Depends on dbm_pkg, dbm_ram and dbm_cmp.
//
// A word is taken when start is high and busy is low, and its result appears
// on rsp for exactly one cycle with done high. The receiver cannot hold a result
// off and must take it in that cycle. Invalid assigns, mmio reads and unused
// kinds finish straight from idle, with done in the cycle after the word is
// taken. Assigns and mmio writes scan the table in order, one entry per cycle
// through the single read port of the table RAM. A deassign scans the same
// way and then moves each later entry down by one, one entry per cycle.
module mmio_write_doorbell_match_table_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  dbm_pkg::in_t  req,
  output logic          done,
  output dbm_pkg::out_t rsp
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  state_t state, state_next;
  dbm_pkg::in_t cur, cur_next;
  dbm_pkg::out_t rsp_next;
  logic done_next;
  logic [dbm_pkg::CNT_W-1:0] count, count_next;
  logic [dbm_pkg::CNT_W-1:0] rd_idx, rd_idx_next;
  logic [dbm_pkg::IDX_W-1:0] pos, pos_next;
  logic cmp_vld, cmp_vld_next;

  logic re, we;
  logic [dbm_pkg::IDX_W-1:0] raddr, waddr;
  logic [dbm_pkg::ENTRY_W-1:0] wdata, rdata;
  dbm_pkg::entry_t rd_ent, new_ent;
  dbm_pkg::cmp_t cmp;

  logic len_ok, ovf, matched, more;
  logic [64:0] end_addr;

  dbm_ram #(
    .WIDTH (dbm_pkg::ENTRY_W),
    .DEPTH (dbm_pkg::TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_ent = dbm_pkg::entry_t'(rdata);

  dbm_cmp u_cmp (
    .ent (rd_ent),
    .cur (cur),
    .res (cmp)
  );

  assign busy = (state != S_IDLE);

  always_comb begin
    len_ok   = req.length inside {4'd0, 4'd1, 4'd2, 4'd4, 4'd8};
    end_addr = {1'b0, req.addr} + {61'd0, req.length};
    ovf      = end_addr[64];
    more     = (rd_idx < count);
    case (cur.kind)
      dbm_pkg::KIND_ASSIGN:   matched = cmp_vld && cmp.conflict;
      dbm_pkg::KIND_DEASSIGN: matched = cmp_vld && cmp.nid_eq;
      default:                matched = cmp_vld && cmp.hit;
    endcase
    new_ent.addr     = cur.addr;
    new_ent.space    = cur.space;
    new_ent.len      = cur.length;
    new_ent.data     = cur.data_match ? cur.data : 64'd0;
    new_ent.wild     = !cur.data_match;
    new_ent.notifier = cur.notifier_id;
  end

  always_comb begin
    state_next   = state;
    cur_next     = cur;
    rsp_next     = rsp;
    done_next    = 1'b0;
    count_next   = count;
    rd_idx_next  = rd_idx;
    pos_next     = pos;
    cmp_vld_next = cmp_vld;
    re           = 1'b0;
    raddr        = rd_idx[dbm_pkg::IDX_W-1:0];
    we           = 1'b0;
    waddr        = pos;
    wdata        = rdata;
    case (state)
      S_IDLE: begin
        if (start) begin
          cur_next     = req;
          rd_idx_next  = '0;
          cmp_vld_next = 1'b0;
          rsp_next     = '0;
          case (req.kind)
            dbm_pkg::KIND_ASSIGN: begin
              if (!len_ok || ovf || ((req.length == 4'd0) && req.data_match)) begin
                rsp_next.status = dbm_pkg::ST_INVALID;
                done_next       = 1'b1;
              end else begin
                state_next = S_SCAN;
              end
            end
            dbm_pkg::KIND_DEASSIGN: begin
              state_next = S_SCAN;
            end
            dbm_pkg::KIND_MMIO: begin
              if (req.is_write) begin
                state_next = S_SCAN;
              end else begin
                rsp_next.status = dbm_pkg::ST_SOFTWARE;
                done_next       = 1'b1;
              end
            end
            default: begin
              rsp_next.status = dbm_pkg::ST_INVALID;
              done_next       = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (matched) begin
          cmp_vld_next = 1'b0;
          case (cur.kind)
            dbm_pkg::KIND_ASSIGN: begin
              rsp_next.status = dbm_pkg::ST_CONFLICT;
              done_next       = 1'b1;
              state_next      = S_IDLE;
            end
            dbm_pkg::KIND_DEASSIGN: begin
              state_next = S_SHIFT;
            end
            default: begin
              rsp_next.status       = dbm_pkg::ST_OK;
              rsp_next.notify       = 1'b1;
              rsp_next.hit_notifier = rd_ent.notifier;
              rsp_next.ack_data     = cur.data;
              done_next             = 1'b1;
              state_next            = S_IDLE;
            end
          endcase
        end else if (more) begin
          re           = 1'b1;
          rd_idx_next  = rd_idx + 1'b1;
          cmp_vld_next = 1'b1;
          pos_next     = rd_idx[dbm_pkg::IDX_W-1:0];
        end else begin
          cmp_vld_next = 1'b0;
          done_next    = 1'b1;
          state_next   = S_IDLE;
          case (cur.kind)
            dbm_pkg::KIND_ASSIGN: begin
              if (count >= dbm_pkg::CNT_W'(dbm_pkg::TABLE_ENTRIES)) begin
                rsp_next.status = dbm_pkg::ST_FULL;
              end else begin
                we              = 1'b1;
                waddr           = count[dbm_pkg::IDX_W-1:0];
                wdata           = new_ent;
                count_next      = count + 1'b1;
                rsp_next.status = dbm_pkg::ST_OK;
              end
            end
            dbm_pkg::KIND_DEASSIGN: begin
              rsp_next.status = dbm_pkg::ST_OK;
            end
            default: begin
              rsp_next.status = dbm_pkg::ST_SOFTWARE;
            end
          endcase
        end
      end
      S_SHIFT: begin
        if (cmp_vld) begin
          we       = 1'b1;
          pos_next = pos + 1'b1;
        end
        if (more) begin
          re           = 1'b1;
          rd_idx_next  = rd_idx + 1'b1;
          cmp_vld_next = 1'b1;
        end else begin
          cmp_vld_next = 1'b0;
          if (!cmp_vld) begin
            count_next      = count - 1'b1;
            rsp_next.status = dbm_pkg::ST_OK;
            done_next       = 1'b1;
            state_next      = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      rd_idx  <= '0;
      cmp_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      rd_idx  <= rd_idx_next;
      cmp_vld <= cmp_vld_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    rsp <= rsp_next;
    pos <= pos_next;
  end

endmodule

// ----- hw/rtl/dbm_chk.sv -----
// Port-level checker for the doorbell match table and its bind statement.
// Depends on dbm_pkg and mmio_write_doorbell_match_table_core.
module dbm_chk (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input dbm_pkg::out_t rsp
);

  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(busy)))
    else $error("Result word without a word in progress.");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("Accepted word neither in progress nor finished.");

  a_notify_ok: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.notify) |-> (rsp.status == dbm_pkg::ST_OK))
    else $error("Notify with a status other than ok.");

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    (done && !rsp.notify) |-> ((rsp.hit_notifier == 16'd0) && (rsp.ack_data == 64'd0)))
    else $error("Hit fields set without notify.");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.status <= dbm_pkg::ST_SOFTWARE))
    else $error("Status code out of range.");

endmodule

bind mmio_write_doorbell_match_table_core dbm_chk u_dbm_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);
